// File: design/ssp_pkg.sv
// shared types and constants for the servo sweep / position controller
// no dependencies; imported by every module of the block
package ssp_pkg;

  // register indexes of the configuration port
  localparam logic [2:0] REG_MODE_SELECT      = 3'd0;
  localparam logic [2:0] REG_ZERO_OFFSET      = 3'd1;
  localparam logic [2:0] REG_UPPER_ENDPOINT   = 3'd2;
  localparam logic [2:0] REG_LOWER_ENDPOINT   = 3'd3;
  localparam logic [2:0] REG_SETTLE_TOLERANCE = 3'd4;
  localparam logic [2:0] REG_ARRIVE_TOLERANCE = 3'd5;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // mode codes
  localparam logic MODE_POSITION = 1'b0;
  localparam logic MODE_SWEEP    = 1'b1;

  // angle full scale in sixteenth ticks and top goal in ticks
  localparam logic signed [17:0] FULL_SCALE = 18'sd16384;
  localparam logic [10:0]        GOAL_MAX   = 11'd1024;

  typedef struct packed {
    logic               mode_select;
    logic signed [15:0] zero_offset;
    logic signed [15:0] upper_endpoint;
    logic signed [15:0] lower_endpoint;
    logic [9:0]         settle_tolerance;
    logic [11:0]        arrive_tolerance;
  } cfg_t;

  typedef struct packed {
    logic [9:0]         present_position;
    logic               command_valid;
    logic signed [15:0] command_angle;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] servo_angle;
    logic               goal_valid;
    logic [10:0]        goal_position;
    logic               last_result;
  } out_item_t;

  // results of one transaction: first result, optional second one
  typedef struct packed {
    out_item_t r0;
    out_item_t r1;
    logic      two;
  } step_res_t;

endpackage

// File: design/ssp_cfg_regs.sv
// configuration register file of the servo sweep / position controller
// depends on ssp_pkg for register indexes and the cfg_t struct
module ssp_cfg_regs
  import ssp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode_select      <= MODE_POSITION;
      cfg.zero_offset      <= 16'sd0;
      cfg.upper_endpoint   <= 16'sd8192;
      cfg.lower_endpoint   <= 16'sd4096;
      cfg.settle_tolerance <= 10'd11;
      cfg.arrive_tolerance <= 12'd218;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MODE_SELECT:      cfg.mode_select      <= cfg_data[0];
        REG_ZERO_OFFSET:      cfg.zero_offset      <= $signed(cfg_data);
        REG_UPPER_ENDPOINT:   cfg.upper_endpoint   <= $signed(cfg_data);
        REG_LOWER_ENDPOINT:   cfg.lower_endpoint   <= $signed(cfg_data);
        REG_SETTLE_TOLERANCE: cfg.settle_tolerance <= cfg_data[9:0];
        REG_ARRIVE_TOLERANCE: cfg.arrive_tolerance <= cfg_data[11:0];
        default: ; // unused indexes are ignored
      endcase
    end
  end

endmodule

// File: design/ssp_step.sv
// per-transaction datapath: present angle, settle/arrive checks, target update, goals
// depends on ssp_pkg; holds the target and previous angle state registers
module ssp_step
  import ssp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      advance,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output step_res_t res
);

  logic signed [16:0] aim_angle, aim_angle_next;
  logic signed [16:0] previous_angle, previous_angle_next;

  function automatic logic [17:0] absdiff(input logic signed [16:0] a,
                                          input logic signed [16:0] b);
    logic signed [17:0] d;
    d = $signed({a[16], a}) - $signed({b[16], b});
    return d[17] ? 18'(-d) : 18'(d);
  endfunction

  // goal ticks from a target angle: offset, clamp, drop the fraction
  function automatic logic [10:0] goal_of(input logic signed [16:0] t,
                                          input logic signed [15:0] off);
    logic signed [17:0] s;
    s = $signed({t[16], t}) + $signed({{2{off[15]}}, off});
    if (s[17]) return 11'd0;
    else if (s > FULL_SCALE) return GOAL_MAX;
    else return s[14:4];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [16:0] a);
    if (a > 17'sd32767) return 16'sh7fff;
    else if (a < -17'sd32768) return 16'sh8000;
    else return a[15:0];
  endfunction

  logic signed [16:0] present, upper_ext, lower_ext, cmd_ext;
  logic               settled, near_up, near_lo, tgt_is_up, tgt_is_lo;
  logic               up_hit, lo_hit, fix;
  logic [10:0]        goal_up, goal_lo, goal_cmd;
  logic signed [15:0] angle_out;

  assign present   = $signed({3'b000, item.present_position, 4'b0000})
                   - $signed({cfg.zero_offset[15], cfg.zero_offset});
  assign upper_ext = {cfg.upper_endpoint[15], cfg.upper_endpoint};
  assign lower_ext = {cfg.lower_endpoint[15], cfg.lower_endpoint};
  assign cmd_ext   = {item.command_angle[15], item.command_angle};

  assign settled   = absdiff(previous_angle, present) < {8'd0, cfg.settle_tolerance};
  assign near_up   = absdiff(present, upper_ext) < {6'd0, cfg.arrive_tolerance};
  assign near_lo   = absdiff(present, lower_ext) < {6'd0, cfg.arrive_tolerance};
  assign tgt_is_up = aim_angle == upper_ext;
  assign tgt_is_lo = aim_angle == lower_ext;

  // upper reached flips to lower; that new target can then flip straight back
  assign up_hit = settled && near_up && tgt_is_up;
  assign lo_hit = settled && near_lo && (up_hit || tgt_is_lo);
  assign fix    = !up_hit && !lo_hit && !tgt_is_up && !tgt_is_lo;

  // the three goals run side by side
  assign goal_up   = goal_of(upper_ext, cfg.zero_offset);
  assign goal_lo   = goal_of(lower_ext, cfg.zero_offset);
  assign goal_cmd  = goal_of(cmd_ext, cfg.zero_offset);
  assign angle_out = sat16(present);

  always_comb begin
    res                  = '0;
    res.r0.servo_angle   = angle_out;
    res.r1.servo_angle   = angle_out;
    res.r1.goal_valid    = 1'b1;
    res.r1.goal_position = goal_up;
    res.r1.last_result   = 1'b1;
    aim_angle_next       = aim_angle;
    previous_angle_next  = previous_angle;
    if (cfg.mode_select == MODE_POSITION) begin
      if (item.command_valid) begin
        aim_angle_next       = cmd_ext;
        previous_angle_next  = present;
        res.r0.goal_valid    = 1'b1;
        res.r0.goal_position = goal_cmd;
      end
    end else begin
      previous_angle_next = present;
      priority if (up_hit) begin
        aim_angle_next       = lo_hit ? upper_ext : lower_ext;
        res.r0.goal_valid    = 1'b1;
        res.r0.goal_position = goal_lo;
        res.two              = lo_hit;
      end else if (lo_hit || fix) begin
        aim_angle_next       = upper_ext;
        res.r0.goal_valid    = 1'b1;
        res.r0.goal_position = goal_up;
      end else begin
        // target stays, no goal write this transaction
      end
    end
    res.r0.last_result = !res.two;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      aim_angle      <= '0;
      previous_angle <= '0;
    end else if (advance) begin
      aim_angle      <= aim_angle_next;
      previous_angle <= previous_angle_next;
    end
  end

endmodule

// File: design/ssp_result_buf.sv
// result register holding up to two results of one transaction
// depends on ssp_pkg; hands them out in order on the output channel
module ssp_result_buf
  import ssp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  step_res_t res_in,
  output logic      can_load,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  step_res_t held;
  logic      full;
  logic      idx;
  logic      pop, pop_last;

  assign pop      = full && out_ready;
  assign pop_last = pop && (idx || !held.two);
  assign can_load = !full || pop_last;
  assign out_valid = full;
  assign out_data  = idx ? held.r1 : held.r0;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      idx  <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
      idx  <= 1'b0;
    end else if (pop_last) begin
      full <= 1'b0;
      idx  <= 1'b0;
    end else if (pop) begin
      idx <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) held <= res_in;
  end

endmodule

// File: design/servo_sweep_position_controller_top.sv
// top level of the servo sweep / position controller
// depends on ssp_pkg, ssp_cfg_regs, ssp_step and ssp_result_buf
//
// usage
// - input channel in_valid/in_ready/in_data: one transaction per servo poll,
//   carrying the present position and an optional commanded angle
// - output channel out_valid/out_ready/out_data: one or two results per input
//   transaction; last_result marks the final one of each
// - configuration: cfg_write with cfg_index/cfg_data writes one register at
//   the clock edge; the user must write only while the block is idle, which
//   the block itself does not enforce
// - flow: an accepted transaction sits in the input register; its results are
//   loaded into the result register once it can take them and offered there
// - throughput: the result register drains one result per cycle while
//   out_ready is high and sets the rate; a new transaction is loaded as the
//   last result of the previous one leaves
// - reset (rst, synchronous): empties both registers, clears target and
//   previous angle and loads the register defaults
// - receiver stall: results stay in the result register, one more
//   transaction waits in the input register, then in_ready drops
module servo_sweep_position_controller_top
  import ssp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_data,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_full;
  logic      can_load;
  logic      move;
  step_res_t res;

  ssp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // the held transaction moves on when the result register can take it
  assign move     = in_full && can_load;
  assign in_ready = !in_full || move;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (move) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_q <= in_data;
  end

  // state advances exactly once per transaction, when its results are stored
  ssp_step u_step (
    .clk     (clk),
    .rst     (rst),
    .advance (move),
    .item    (in_q),
    .cfg     (cfg),
    .res     (res)
  );

  ssp_result_buf u_rbuf (
    .clk       (clk),
    .rst       (rst),
    .load      (move),
    .res_in    (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // a first result that is not last is followed by the final one
  a_second_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.last_result |=> out_valid && out_data.last_result)
    else $error("second result of a transaction missing");

  // the input side only stalls behind waiting results
  a_stall_reason: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> in_full && out_valid)
    else $error("input stalled with no result waiting");

  // a transaction handed to the result register shows up on the output
  a_move_shows: assert property (@(posedge clk) disable iff (rst)
    move |=> out_valid)
    else $error("stored results not presented");

endmodule
